[sv/plr_pkg.sv]
// Shared types and constants of the polyline line rasterizer.
// No dependencies.
package plr_pkg;

  localparam int unsigned COORD_W = 6;

  typedef logic [COORD_W-1:0] coord_t;

  typedef struct packed {
    logic store;
    logic capture;
    logic setup;
    logic emit;
  } plr_cmd_t;

  typedef struct packed {
    logic store_only;
    logic last;
    logic out_free;
  } plr_status_t;

endpackage

[sv/plr_if.sv]
// Vertex and pixel channel interfaces, valid/ready with payload.
// Depends on plr_pkg.
interface plr_vertex_if import plr_pkg::*; ();
  logic   valid;
  logic   ready;
  coord_t vertex_x;
  coord_t vertex_y;
  logic   first_vertex;

  modport source (output valid, output vertex_x, output vertex_y, output first_vertex,
                  input ready);
  modport sink (input valid, input vertex_x, input vertex_y, input first_vertex,
                output ready);
endinterface

interface plr_pixel_if import plr_pkg::*; ();
  logic   valid;
  logic   ready;
  coord_t pixel_x;
  coord_t pixel_y;
  logic   last_pixel;

  modport source (output valid, output pixel_x, output pixel_y, output last_pixel,
                  input ready);
  modport sink (input valid, input pixel_x, input pixel_y, input last_pixel,
                output ready);
endinterface

[sv/plr_ctrl.sv]
// Sequencer of the rasterizer: accept, segment setup, pixel stepping.
// Depends on plr_pkg; drives plr_datapath through plr_cmd_t.
module plr_ctrl import plr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  plr_status_t status_i,
  output plr_cmd_t    cmd_o
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SETUP = 2'd1;
  localparam logic [1:0] ST_DRAW  = 2'd2;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (status_i.store_only) begin
            cmd_o.store = 1'b1;
          end else begin
            cmd_o.capture = 1'b1;
            state_d       = ST_SETUP;
          end
        end
      end
      ST_SETUP: begin
        cmd_o.setup = 1'b1;
        state_d     = ST_DRAW;
      end
      ST_DRAW: begin
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (status_i.last) state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  a_setup_then_draw: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SETUP |=> state_q == ST_DRAW)
    else $error("setup not followed by draw");

  a_emit_in_draw: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |-> state_q == ST_DRAW && !in_ready_o)
    else $error("pixel emitted outside draw");

  a_ready_in_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> state_q == ST_IDLE)
    else $error("vertex accepted while busy");

endmodule

[sv/plr_datapath.sv]
// Bresenham datapath: stored vertex, segment setup, error stepping, output register.
// Depends on plr_pkg; commanded by plr_ctrl.
module plr_datapath import plr_pkg::*; #(
  parameter int unsigned COORD_BITS = 6
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  plr_cmd_t    cmd_i,
  output plr_status_t status_o,
  input  coord_t      vertex_x_i,
  input  coord_t      vertex_y_i,
  input  logic        first_vertex_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output coord_t      pixel_x_o,
  output coord_t      pixel_y_o,
  output logic        last_pixel_o
);

  localparam int unsigned EW = COORD_BITS + 3;

  typedef logic [COORD_BITS-1:0] gc_t;

  logic            have_prev_q;
  gc_t             prev_x_q, prev_y_q, cur_x_q, cur_y_q;
  logic            steep_q, dec_q;
  gc_t             maj_q, maj_end_q, min_q, dmaj_q, dmin_q;
  logic signed [EW-1:0] err_q;
  coord_t          pix_x_q, pix_y_q;
  logic            pix_last_q, out_valid_q;

  gc_t  in_x, in_y;
  gc_t  adx, ady;
  logic steep;
  gc_t  sax, say, sbx, sby;
  gc_t  ax, ay, bx, by;
  logic signed [EW-1:0] err_sum, err_dbl, dmaj_s;
  logic step_minor;

  assign in_x = vertex_x_i[COORD_BITS-1:0];
  assign in_y = vertex_y_i[COORD_BITS-1:0];

  always_comb begin
    adx   = (cur_x_q > prev_x_q) ? cur_x_q - prev_x_q : prev_x_q - cur_x_q;
    ady   = (cur_y_q > prev_y_q) ? cur_y_q - prev_y_q : prev_y_q - cur_y_q;
    steep = ady > adx;
    sax   = steep ? prev_y_q : prev_x_q;
    say   = steep ? prev_x_q : prev_y_q;
    sbx   = steep ? cur_y_q  : cur_x_q;
    sby   = steep ? cur_x_q  : cur_y_q;
    if (sax > sbx) begin
      ax = sbx; ay = sby; bx = sax; by = say;
    end else begin
      ax = sax; ay = say; bx = sbx; by = sby;
    end
  end

  always_comb begin
    dmaj_s     = $signed(EW'(dmaj_q));
    err_sum    = err_q + $signed(EW'(dmin_q));
    err_dbl    = err_sum <<< 1;
    step_minor = err_dbl >= dmaj_s;
  end

  assign status_o.store_only = first_vertex_i || !have_prev_q;
  assign status_o.last       = maj_q == maj_end_q;
  assign status_o.out_free   = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_prev_q <= 1'b0;
      prev_x_q    <= '0;
      prev_y_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.store) begin
        have_prev_q <= 1'b1;
        prev_x_q    <= in_x;
        prev_y_q    <= in_y;
      end else if (cmd_i.setup) begin
        prev_x_q <= cur_x_q;
        prev_y_q <= cur_y_q;
      end
      if (cmd_i.emit) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      cur_x_q <= in_x;
      cur_y_q <= in_y;
    end
    if (cmd_i.setup) begin
      steep_q   <= steep;
      maj_q     <= ax;
      maj_end_q <= bx;
      min_q     <= ay;
      dmaj_q    <= bx - ax;
      dmin_q    <= (by > ay) ? by - ay : ay - by;
      dec_q     <= !(ay < by);
      err_q     <= '0;
    end else if (cmd_i.emit) begin
      pix_x_q    <= COORD_W'(steep_q ? min_q : maj_q);
      pix_y_q    <= COORD_W'(steep_q ? maj_q : min_q);
      pix_last_q <= maj_q == maj_end_q;
      maj_q      <= maj_q + 1'b1;
      if (step_minor) begin
        min_q <= dec_q ? min_q - 1'b1 : min_q + 1'b1;
        err_q <= err_sum - dmaj_s;
      end else begin
        err_q <= err_sum;
      end
    end
  end

  assign out_valid_o  = out_valid_q;
  assign pixel_x_o    = pix_x_q;
  assign pixel_y_o    = pix_y_q;
  assign last_pixel_o = pix_last_q;

  a_emit_has_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> !out_valid_q || out_ready_i)
    else $error("pixel overwritten before taken");

  a_major_steps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit && !status_o.last |=> maj_q == $past(maj_q) + 1'b1)
    else $error("major coordinate did not advance");

  a_pixel_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_ready_i |=> out_valid_q && $stable({pix_x_q, pix_y_q, pix_last_q}))
    else $error("waiting pixel changed");

endmodule

[sv/polyline_line_rasterizer.sv]
// Polyline line rasterizer: Bresenham segments between consecutive vertices.
// A drawn segment goes through accept, setup, then one pixel per cycle from the stepping
// datapath while the output register is free; each pixel is registered before it shows.
// A first vertex is stored in its accept cycle and the next vertex is taken at once.
// Reset (async, active low) clears the stored vertex and the output valid flag.
// Depends on plr_pkg, plr_if, plr_ctrl, plr_datapath.
module polyline_line_rasterizer import plr_pkg::*; #(
  parameter int unsigned COORD_BITS = 6
) (
  input logic          clk_i,
  input logic          rst_ni,
  plr_vertex_if.sink   vtx_i,
  plr_pixel_if.source  pix_o
);

  plr_cmd_t    cmd;
  plr_status_t status;

  plr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (vtx_i.valid),
    .in_ready_o (vtx_i.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  plr_datapath #(
    .COORD_BITS (COORD_BITS)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .vertex_x_i     (vtx_i.vertex_x),
    .vertex_y_i     (vtx_i.vertex_y),
    .first_vertex_i (vtx_i.first_vertex),
    .out_valid_o    (pix_o.valid),
    .out_ready_i    (pix_o.ready),
    .pixel_x_o      (pix_o.pixel_x),
    .pixel_y_o      (pix_o.pixel_y),
    .last_pixel_o   (pix_o.last_pixel)
  );

endmodule

[sim/polyline_line_rasterizer_test.sv]
// Testbench for polyline_line_rasterizer: drives vertex items, predicts each pixel
// of the Bresenham segments and checks every pixel item in order.
// Depends on plr_pkg, plr_if and the rasterizer RTL.
module polyline_line_rasterizer_test import plr_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int N_DIRECTED  = 19;
  localparam int N_RANDOM    = 117;   // per idling phase
  localparam int HOLD_CYCLES = 400;
  localparam int IDLE_LIMIT  = 5000;
  localparam int DRAIN_WAIT  = 16;

  typedef struct packed {
    coord_t px_x;
    coord_t px_y;
    logic   is_last;
  } pixel_t;

  typedef struct packed {
    coord_t vx;
    coord_t vy;
    logic   first;
    logic   typed;    // use typed pixel below instead of the predictor
    logic   one_px;   // typed row emits one pixel, else none
    pixel_t px;
  } vertex_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  plr_vertex_if vtx ();
  plr_pixel_if  pix ();

  polyline_line_rasterizer #(
    .COORD_BITS(6)
  ) i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .vtx_i (vtx),
    .pix_o (pix)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // stored vertex of the predictor
  coord_t anchor_x = '0;
  coord_t anchor_y = '0;
  bit     anchor_valid = 1'b0;

  pixel_t seg_pixels[$];
  pixel_t pending_pixels[$];
  pixel_t want;
  int     n_errors = 0;
  int     src_idle = 0;
  int     snk_idle = 0;
  bit     hold_pixels = 1'b0;
  int     quiet_cycles = 0;

  vertex_row_t directed_rows [N_DIRECTED];

  function automatic int span(int a, int b);
    return (a > b) ? a - b : b - a;
  endfunction

  // Bresenham segment from the stored vertex to (vx, vy), into seg_pixels
  function automatic void plot_vertex(coord_t vx, coord_t vy, logic first);
    int ax, ay, bx, by, t, dmaj, dmin, err, minor, stp, m;
    logic steep;
    pixel_t p;
    seg_pixels.delete();
    if (first || !anchor_valid) begin
      anchor_x = vx;
      anchor_y = vy;
      anchor_valid = 1'b1;
      return;
    end
    ax = int'(anchor_x);
    ay = int'(anchor_y);
    bx = int'(vx);
    by = int'(vy);
    steep = span(by, ay) > span(bx, ax);
    if (steep) begin
      t = ax; ax = ay; ay = t;
      t = bx; bx = by; by = t;
    end
    if (ax > bx) begin
      t = ax; ax = bx; bx = t;
      t = ay; ay = by; by = t;
    end
    dmaj = bx - ax;
    dmin = span(by, ay);
    err = 0;
    minor = ay;
    stp = (ay < by) ? 1 : -1;
    for (m = ax; m <= bx; m++) begin
      p.px_x = coord_t'(steep ? minor : m);
      p.px_y = coord_t'(steep ? m : minor);
      p.is_last = (m == bx);
      seg_pixels.push_back(p);
      err += dmin;
      if (2 * err >= dmaj) begin
        minor += stp;
        err -= dmaj;
      end
    end
    anchor_x = vx;
    anchor_y = vy;
  endfunction

  function automatic void note_mismatch(string what, pixel_t exp_px, pixel_t got_px);
    n_errors++;
    if (n_errors <= 10) begin
      $display("%0t: %s: expected x=%0d y=%0d last=%0b, got x=%0d y=%0d last=%0b", $realtime,
               what, exp_px.px_x, exp_px.px_y, exp_px.is_last,
               got_px.px_x, got_px.px_y, got_px.is_last);
    end
  endfunction

  // Entered anywhere; returns at the accepting edge with seg_pixels predicted.
  task automatic offer_vertex(coord_t x, coord_t y, logic first);
    @(negedge clk_i);
    while ($urandom_range(99) < src_idle) begin
      vtx.valid <= 1'b0;
      @(negedge clk_i);
    end
    vtx.valid        <= 1'b1;
    vtx.vertex_x     <= x;
    vtx.vertex_y     <= y;
    vtx.first_vertex <= first;
    do @(posedge clk_i); while (!vtx.ready);
    plot_vertex(x, y, first);
  endtask

  // pixel receiver
  initial begin
    pix.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_pixels) begin
        hold_pixels = 1'b0;
        pix.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
      end else begin
        pix.ready <= ($urandom_range(99) >= snk_idle);
      end
    end
  end

  // pixel checker
  always @(posedge clk_i) begin
    if (rst_ni && pix.valid && pix.ready) begin
      if (pending_pixels.size() == 0) begin
        note_mismatch("unexpected pixel", '0, {pix.pixel_x, pix.pixel_y, pix.last_pixel});
      end else begin
        want = pending_pixels.pop_front();
        if (pix.pixel_x !== want.px_x || pix.pixel_y !== want.px_y ||
            pix.last_pixel !== want.is_last) begin
          note_mismatch("pixel mismatch", want, {pix.pixel_x, pix.pixel_y, pix.last_pixel});
        end
      end
    end
  end

  // watchdog on cycles without any accepted item
  always @(posedge clk_i) begin
    if ((vtx.valid && vtx.ready) || (pix.valid && pix.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    int i, ph, pick;
    coord_t nx, ny, cur_x, cur_y;
    logic nf;

    vtx.valid = 1'b0;
    vtx.vertex_x = '0;
    vtx.vertex_y = '0;
    vtx.first_vertex = 1'b0;

    //                 x      y     first typed one  typed pixel
    directed_rows = '{
      '{6'd5,  6'd7,  1'b0, 1'b1, 1'b0, '0},                    // nothing stored yet
      '{6'd5,  6'd7,  1'b0, 1'b1, 1'b1, '{6'd5, 6'd7, 1'b1}},   // zero-length segment
      '{6'd0,  6'd0,  1'b1, 1'b1, 1'b0, '0},
      '{6'd63, 6'd0,  1'b0, 1'b0, 1'b0, '0},                    // full-width row
      '{6'd63, 6'd63, 1'b0, 1'b0, 1'b0, '0},                    // full-height column
      '{6'd0,  6'd0,  1'b0, 1'b0, 1'b0, '0},                    // drawn from the new end
      '{6'd63, 6'd63, 1'b0, 1'b0, 1'b0, '0},
      '{6'd0,  6'd63, 1'b0, 1'b0, 1'b0, '0},
      '{6'd63, 6'd0,  1'b0, 1'b0, 1'b0, '0},                    // y stepping down
      '{6'd0,  6'd63, 1'b1, 1'b1, 1'b0, '0},
      '{6'd0,  6'd63, 1'b0, 1'b1, 1'b1, '{6'd0, 6'd63, 1'b1}},
      '{6'd10, 6'd0,  1'b0, 1'b0, 1'b0, '0},
      '{6'd63, 6'd5,  1'b0, 1'b0, 1'b0, '0},
      '{6'd42, 6'd21, 1'b0, 1'b0, 1'b0, '0},
      '{6'd21, 6'd42, 1'b1, 1'b1, 1'b0, '0},
      '{6'd22, 6'd42, 1'b0, 1'b0, 1'b0, '0},
      '{6'd21, 6'd43, 1'b0, 1'b0, 1'b0, '0},
      '{6'd63, 6'd63, 1'b0, 1'b0, 1'b0, '0},
      '{6'd42, 6'd21, 1'b0, 1'b0, 1'b0, '0}
    };

    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;

    src_idle = 18;
    snk_idle = 84;
    for (i = 0; i < N_DIRECTED; i++) begin
      offer_vertex(directed_rows[i].vx, directed_rows[i].vy, directed_rows[i].first);
      if (directed_rows[i].typed) begin
        if (directed_rows[i].one_px) pending_pixels.push_back(directed_rows[i].px);
      end else begin
        foreach (seg_pixels[k]) pending_pixels.push_back(seg_pixels[k]);
      end
    end

    cur_x = directed_rows[N_DIRECTED-1].vx;
    cur_y = directed_rows[N_DIRECTED-1].vy;
    for (ph = 0; ph < 3; ph++) begin
      src_idle = (ph == 0) ? 18 : (ph == 1) ? 84 : 0;
      snk_idle = (ph == 0) ? 84 : (ph == 1) ? 18 : 0;
      if (ph == 2) hold_pixels = 1'b1;
      for (i = 0; i < N_RANDOM; i++) begin
        nf = ($urandom_range(7) == 0);
        pick = $urandom_range(9);
        if (pick < 6) begin
          nx = coord_t'($urandom_range(63));
          ny = coord_t'($urandom_range(63));
        end else if (pick < 9) begin
          // short hops, wrapping at the grid edge
          nx = coord_t'(int'(cur_x) + int'($urandom_range(6)) - 3);
          ny = coord_t'(int'(cur_y) + int'($urandom_range(6)) - 3);
        end else begin
          nx = cur_x;
          ny = cur_y;
        end
        offer_vertex(nx, ny, nf);
        foreach (seg_pixels[k]) pending_pixels.push_back(seg_pixels[k]);
        cur_x = nx;
        cur_y = ny;
      end
    end

    @(negedge clk_i);
    vtx.valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);

    if (pending_pixels.size() != 0) n_errors++;
    if (n_errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

[filelist.f]
sv/plr_pkg.sv
sv/plr_if.sv
sv/plr_ctrl.sv
sv/plr_datapath.sv
sv/polyline_line_rasterizer.sv
sim/polyline_line_rasterizer_test.sv
